// ===== hdl/matrix_vector_transform_q16_macros.svh =====
// Assertion helpers shared by the matrix/vector transform RTL.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef MATRIX_VECTOR_TRANSFORM_Q16_MACROS_SVH
`define MATRIX_VECTOR_TRANSFORM_Q16_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MVT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mvt assertion failed");

// consequent must hold in the cycle after the antecedent
`define MVT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mvt assertion failed");

`endif

// ===== hdl/mvt_pkg.sv =====
`default_nettype none

package mvt_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int NUM_ROWS = 3;
    localparam int NUM_COLS = 3;
    localparam int IDX_W    = 4;

    // request kinds carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // one vector or one row of results, element 0 in the lowest bits
    typedef logic [NUM_COLS-1:0][DATA_W-1:0] vec_t;

    // decoded matrix entry position
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] col;
    } entry_loc_t;

    // control from the top level to one row lane
    typedef struct packed {
        logic              wr_en;
        logic [1:0]        wr_col;
        logic [DATA_W-1:0] wr_data;
        logic              cap_en;
    } lane_ctrl_t;

    // row * 3 + column back to row and column; indices 9..15 are ignored
    function automatic entry_loc_t entry_decode(logic [IDX_W-1:0] idx);
        entry_loc_t loc;
        loc = '0;
        unique case (idx)
            4'd0: loc = '{valid: 1'b1, row: 2'd0, col: 2'd0};
            4'd1: loc = '{valid: 1'b1, row: 2'd0, col: 2'd1};
            4'd2: loc = '{valid: 1'b1, row: 2'd0, col: 2'd2};
            4'd3: loc = '{valid: 1'b1, row: 2'd1, col: 2'd0};
            4'd4: loc = '{valid: 1'b1, row: 2'd1, col: 2'd1};
            4'd5: loc = '{valid: 1'b1, row: 2'd1, col: 2'd2};
            4'd6: loc = '{valid: 1'b1, row: 2'd2, col: 2'd0};
            4'd7: loc = '{valid: 1'b1, row: 2'd2, col: 2'd1};
            4'd8: loc = '{valid: 1'b1, row: 2'd2, col: 2'd2};
            default: loc = '{valid: 1'b0, row: 2'd0, col: 2'd0};
        endcase
        return loc;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mvt_lane.sv =====
`default_nettype none

// One matrix row: holds its three entries, forms three fixed-point
// products into a register, and sums them for the merge stage.
module mvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire                              aclk,
    input  wire mvt_pkg::lane_ctrl_t         ctrl,
    input  wire mvt_pkg::vec_t               vec,
    output logic [mvt_pkg::DATA_W-1:0]       sum
);

    logic [mvt_pkg::DATA_W-1:0]        entry_reg [mvt_pkg::NUM_COLS];
    logic [mvt_pkg::DATA_W-1:0]        prod_reg  [mvt_pkg::NUM_COLS];
    logic [mvt_pkg::DATA_W-1:0]        prod_next [mvt_pkg::NUM_COLS];
    logic signed [mvt_pkg::PROD_W-1:0] full_prod [mvt_pkg::NUM_COLS];

    // full signed product, arithmetic shift by the fraction, keep 32 bits
    always_comb begin
        for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
            full_prod[c] = mvt_pkg::PROD_W'(signed'(entry_reg[c]))
                         * mvt_pkg::PROD_W'(signed'(vec[c]));
            prod_next[c] = full_prod[c][FRAC_BITS +: mvt_pkg::DATA_W];
        end
    end

    // entry writes and product capture; payload only, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            entry_reg[ctrl.wr_col] <= ctrl.wr_data;
        end
        if (ctrl.cap_en) begin
            for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // row sum wraps at 32 bits
    assign sum = prod_reg[0] + prod_reg[1] + prod_reg[2];

endmodule

`default_nettype wire

// ===== hdl/mvt_merge.sv =====
`default_nettype none

// Gathers the three row sums into the output register and drives the
// result channel; frees itself whenever the receiver takes the result.
module mvt_merge (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    in_valid,
    input  wire mvt_pkg::vec_t                     in_sums,
    output logic                                   in_ready,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    output logic [mvt_pkg::NUM_ROWS*mvt_pkg::DATA_W-1:0] m_tdata
);

    logic          valid_reg;
    logic          valid_next;
    mvt_pkg::vec_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    // output valid follows the upstream stage when the register is free
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_sums;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/matrix_vector_transform_q16.sv =====
// 3x3 fixed-point matrix by vector transform, signed Q(32-FRAC_BITS).FRAC_BITS.
// Input channel s_*: one request per tvalid/tready handshake. tuser selects the
// kind: load writes matrix entry row*3+col (indices 9..15 are dropped) and gives
// no result; transform multiplies the stored matrix by (x, y, z). Load every
// entry a transform reads before sending it.
// Result channel m_*: one result per transform, out_x/out_y/out_z are rows 0..2.
// A transform's products are registered in the product stage, its row sums in
// the output register that drives m_*. Throughput: one request per cycle while
// s_tready is high, loads and transforms in any mix, from three row lanes of three
// 32x32 multipliers each, one product register stage and one output register.
// Stall: while m_tready is low the result holds; one more transform is taken
// into the product stage, then s_tready drops. Loads are taken only when
// s_tready is high, after any transform ahead of them has latched its products.
// Reset (aresetn low, synchronous) empties both stages; matrix contents are
// not cleared and stay undefined until written.
`default_nettype none

`include "matrix_vector_transform_q16_macros.svh"

module matrix_vector_transform_q16 #(
    parameter int FRAC_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [3:0] entry_index, [35:4] entry_value, [67:36] vec_x,
    // [99:68] vec_y, [131:100] vec_z, [135:132] zero
    input  wire  [135:0] s_tdata,
    // [0] opcode
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [95:0]  m_tdata
);

    localparam int DW = mvt_pkg::DATA_W;

    logic                  s_accept;
    logic                  load_acc;
    logic                  xform_acc;
    logic                  s1_ready;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    mvt_pkg::entry_loc_t   loc;
    mvt_pkg::vec_t         vec;
    mvt_pkg::vec_t         row_sums;
    mvt_pkg::lane_ctrl_t   lane_ctrl [mvt_pkg::NUM_ROWS];

    // request decode
    assign s_tready  = !s1_valid_reg || s1_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign load_acc  = s_accept && (s_tuser[0] == mvt_pkg::OP_LOAD);
    assign xform_acc = s_accept && (s_tuser[0] == mvt_pkg::OP_XFORM);
    assign loc       = mvt_pkg::entry_decode(s_tdata[mvt_pkg::IDX_W-1:0]);

    assign vec[0] = s_tdata[36 +: DW];
    assign vec[1] = s_tdata[68 +: DW];
    assign vec[2] = s_tdata[100 +: DW];

    // product stage occupancy
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_tready) begin
            s1_valid_next = xform_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // one lane per matrix row
    for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++) begin : g_lane
        always_comb begin
            lane_ctrl[r].wr_en   = load_acc && loc.valid && (loc.row == 2'(r));
            lane_ctrl[r].wr_col  = loc.col;
            lane_ctrl[r].wr_data = s_tdata[4 +: DW];
            lane_ctrl[r].cap_en  = xform_acc;
        end

        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .ctrl (lane_ctrl[r]),
            .vec  (vec),
            .sum  (row_sums[r])
        );
    end

    // output register
    mvt_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_sums  (row_sums),
        .in_ready (s1_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // checks
    `MVT_ASSERT_SAME(a_ready_when_out_free, aclk, aresetn, !m_tvalid, s_tready)
    `MVT_ASSERT_NEXT(a_xform_enters_stage, aclk, aresetn, xform_acc, s1_valid_reg)
    `MVT_ASSERT_NEXT(a_load_no_result, aclk, aresetn, load_acc && !s1_valid_reg, !s1_valid_reg)

endmodule

`default_nettype wire
